// File: rtl/trzb_pkg.sv
// ----------------------------------------------------------------------------
// trzb_pkg: shared types and constants of the triangle rasteriser
// widths of the request fields, action codes, controller states and the
// command / status groups between controller and datapath
// ----------------------------------------------------------------------------
package trzb_pkg;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 24;
   localparam int ACTION_W   = 2;
   localparam int COORD_W    = 12;
   localparam int DEPTH_W    = 16;
   localparam int COLOR_W    = 24;
   localparam int INDEX_W    = 16;
   localparam int BOX_W      = 11;   // pixel coordinate, holds up to 2047
   localparam int STEP_W     = 13;   // edge slope, signed vertex difference
   localparam int EDGE_W     = 28;   // signed edge value
   localparam int MAG_W      = 27;   // edge magnitude
   localparam int SUM_W      = 29;   // sum of three magnitudes
   localparam int ACC_W      = 45;   // weighted depth sum
   localparam int SDEPTH_W   = 17;   // stored sample depth
   localparam int SAMPLE_W   = SDEPTH_W + COLOR_W;
   localparam int QUO_W      = 16;

   localparam logic [SDEPTH_W-1:0] DEPTH_FAR = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR = 2'd0,
      ACT_DRAW  = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_BOOT_CLEAR,
      ST_IDLE,
      ST_CLEAR,
      ST_BOX,
      ST_SETUP,
      ST_TEST,
      ST_MAC,
      ST_DIV,
      ST_UPDATE,
      ST_RESOLVE,
      ST_STEP,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clr_write;
      logic box;
      logic setup;
      logic test;
      logic mac;
      logic div;
      logic update;
      logic resolve;
      logic step;
      logic res_read;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic box_empty;
      logic setup_last;
      logic covered;
      logic mac_last;
      logic div_last;
      logic sample_last;
      logic walk_last;
   } status_type;

endpackage

// File: rtl/trzb_ctrl.sv
// ----------------------------------------------------------------------------
// trzb_ctrl: sequencing state machine
// runs the clear sweep, the per-sample draw sequence, reads and the
// request / response handshake
// ----------------------------------------------------------------------------
module trzb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  trzb_pkg::action_type  req_action,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  trzb_pkg::status_type  status,
   output trzb_pkg::cmd_type     cmd
);

   trzb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         trzb_pkg::ST_BOOT_CLEAR: begin
            if (status.clr_last) state_in = trzb_pkg::ST_IDLE;
         end
         trzb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (req_action)
                  trzb_pkg::ACT_CLEAR: state_in = trzb_pkg::ST_CLEAR;
                  trzb_pkg::ACT_DRAW:  state_in = trzb_pkg::ST_BOX;
                  trzb_pkg::ACT_READ:  state_in = trzb_pkg::ST_READ;
                  default:             state_in = trzb_pkg::ST_IDLE;
               endcase
            end
         end
         trzb_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = trzb_pkg::ST_FINISH;
         end
         trzb_pkg::ST_BOX: state_in = trzb_pkg::ST_SETUP;
         trzb_pkg::ST_SETUP: begin
            if (status.box_empty)       state_in = trzb_pkg::ST_FINISH;
            else if (status.setup_last) state_in = trzb_pkg::ST_TEST;
         end
         trzb_pkg::ST_TEST: begin
            state_in = status.covered ? trzb_pkg::ST_MAC : trzb_pkg::ST_UPDATE;
         end
         trzb_pkg::ST_MAC: begin
            if (status.mac_last) state_in = trzb_pkg::ST_DIV;
         end
         trzb_pkg::ST_DIV: begin
            if (status.div_last) state_in = trzb_pkg::ST_UPDATE;
         end
         trzb_pkg::ST_UPDATE: begin
            state_in = status.sample_last ? trzb_pkg::ST_RESOLVE : trzb_pkg::ST_TEST;
         end
         trzb_pkg::ST_RESOLVE: state_in = trzb_pkg::ST_STEP;
         trzb_pkg::ST_STEP: begin
            state_in = status.walk_last ? trzb_pkg::ST_FINISH : trzb_pkg::ST_TEST;
         end
         trzb_pkg::ST_READ: state_in = trzb_pkg::ST_FINISH;
         trzb_pkg::ST_FINISH: begin
            if (rsp_free) state_in = trzb_pkg::ST_IDLE;
         end
         default: state_in = trzb_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         trzb_pkg::ST_BOOT_CLEAR: cmd.clr_write = 1'b1;
         trzb_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         trzb_pkg::ST_CLEAR:   cmd.clr_write = 1'b1;
         trzb_pkg::ST_BOX:     cmd.box       = 1'b1;
         trzb_pkg::ST_SETUP:   cmd.setup     = !status.box_empty;
         trzb_pkg::ST_TEST:    cmd.test      = 1'b1;
         trzb_pkg::ST_MAC:     cmd.mac       = 1'b1;
         trzb_pkg::ST_DIV:     cmd.div       = 1'b1;
         trzb_pkg::ST_UPDATE:  cmd.update    = 1'b1;
         trzb_pkg::ST_RESOLVE: cmd.resolve   = 1'b1;
         trzb_pkg::ST_STEP:    cmd.step      = !status.walk_last;
         trzb_pkg::ST_READ:    cmd.res_read  = 1'b1;
         trzb_pkg::ST_FINISH:  cmd.load_rsp  = rsp_free;
         default:              cmd           = '0;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp)  rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trzb_pkg::ST_BOOT_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/trzb_datapath.sv
// ----------------------------------------------------------------------------
// trzb_datapath: edge walker, depth divider and frame stores
// incremental edge functions, barycentric depth by multiply-accumulate and
// restoring division, sample and resolved colour memories
// ----------------------------------------------------------------------------
module trzb_datapath #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [trzb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [trzb_pkg::ACTION_W-1:0]     req_tuser,
   input  trzb_pkg::cmd_type                 cmd,
   output trzb_pkg::status_type              status,
   output logic [trzb_pkg::COLOR_W-1:0]      rsp_color,
   output logic [trzb_pkg::ACTION_W-1:0]     rsp_action
);

   localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int SAMPLE_COUNT = PIXEL_COUNT * 4;
   localparam int PA_W         = $clog2(PIXEL_COUNT);
   localparam int SA_W         = PA_W + 2;

   localparam int CW  = trzb_pkg::COORD_W;
   localparam int BW  = trzb_pkg::BOX_W;
   localparam int EW  = trzb_pkg::EDGE_W;
   localparam int SW  = trzb_pkg::STEP_W;
   localparam int MW  = trzb_pkg::MAG_W;
   localparam int AW  = trzb_pkg::ACC_W;
   localparam int QW  = trzb_pkg::QUO_W;
   localparam int DW  = trzb_pkg::DEPTH_W;
   localparam int KW  = trzb_pkg::COLOR_W;

   // frame stores
   logic [trzb_pkg::SAMPLE_W-1:0] samp_mem [SAMPLE_COUNT];
   logic [KW-1:0]                 res_mem  [PIXEL_COUNT];

   // latched request
   logic [CW-1:0]                  vx_ff [3];
   logic [CW-1:0]                  vy_ff [3];
   logic [DW-1:0]                  vz_ff [3];
   logic [KW-1:0]                  color_ff;
   logic [trzb_pkg::INDEX_W-1:0]   index_ff;
   logic [trzb_pkg::ACTION_W-1:0]  act_ff;

   // walk state
   logic [BW-1:0] x0_ff, x1_ff, y0_ff, y1_ff, px_ff, py_ff;
   logic [PA_W-1:0] pix_ff, col_pix_ff;
   logic signed [EW-1:0] edge_base_ff [3];
   logic signed [EW-1:0] edge_pix_ff  [3];
   logic signed [SW-1:0] fx_ff [3];
   logic signed [SW-1:0] fy_ff [3];

   // control counters
   logic [SA_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]      setup_cnt_ff, setup_cnt_in;
   logic [1:0]      mac_cnt_ff, mac_cnt_in;
   logic [3:0]      div_cnt_ff, div_cnt_in;
   logic [1:0]      s_ff, s_in;
   logic            hit_ff, hit_in;

   // per-sample arithmetic
   logic [MW-1:0]   mag_ff [3];
   logic            covered_ff;
   logic [AW-1:0]   acc_ff, dvs_ff;
   logic [QW-1:0]   quo_ff;
   logic [trzb_pkg::SAMPLE_W-1:0] samp_rdata_ff;
   logic [KW-1:0]   col_ff [4];
   logic [KW-1:0]   res_rdata_ff;
   logic [KW-1:0]   rsp_color_ff;
   logic [trzb_pkg::ACTION_W-1:0] rsp_action_ff;

   // ---------------------------------------------------------------- box
   logic [CW-1:0] lx, hx, ly, hy;
   logic [BW-1:0] x1_raw, y1_raw, x1_clip, y1_clip;

   always_comb begin
      lx = vx_ff[0]; hx = vx_ff[0];
      ly = vy_ff[0]; hy = vy_ff[0];
      for (int k = 1; k < 3; k++) begin
         if (vx_ff[k] < lx) lx = vx_ff[k];
         if (vx_ff[k] > hx) hx = vx_ff[k];
         if (vy_ff[k] < ly) ly = vy_ff[k];
         if (vy_ff[k] > hy) hy = vy_ff[k];
      end
   end

   assign x1_raw  = BW'(({1'b0, hx} + 13'd15) >> 4);
   assign y1_raw  = BW'(({1'b0, hy} + 13'd15) >> 4);
   assign x1_clip = (x1_raw > BW'(FRAME_WIDTH - 1))  ? BW'(FRAME_WIDTH - 1)  : x1_raw;
   assign y1_clip = (y1_raw > BW'(FRAME_HEIGHT - 1)) ? BW'(FRAME_HEIGHT - 1) : y1_raw;

   // ---------------------------------------------------------------- edge setup
   logic [CW-1:0] ax, ay, bx, by;
   logic [13:0]   sx0, sy0;
   logic signed [SW-1:0] bax, bay;
   logic signed [14:0]   sxa, sya;
   logic signed [EW-1:0] prod_a, prod_b, edge_org;
   logic [PA_W-1:0]      row_addr;

   always_comb begin
      case (setup_cnt_ff)
         2'd0: begin
            ax = vx_ff[0]; ay = vy_ff[0]; bx = vx_ff[1]; by = vy_ff[1];
         end
         2'd1: begin
            ax = vx_ff[1]; ay = vy_ff[1]; bx = vx_ff[2]; by = vy_ff[2];
         end
         default: begin
            ax = vx_ff[2]; ay = vy_ff[2]; bx = vx_ff[0]; by = vy_ff[0];
         end
      endcase
   end

   assign sx0      = 14'({x0_ff[7:0], 4'd4});
   assign sy0      = 14'({y0_ff[7:0], 4'd4});
   assign bax      = $signed({1'b0, bx}) - $signed({1'b0, ax});
   assign bay      = $signed({1'b0, by}) - $signed({1'b0, ay});
   assign sxa      = $signed({1'b0, sx0}) - $signed({3'b000, ax});
   assign sya      = $signed({1'b0, sy0}) - $signed({3'b000, ay});
   assign prod_a   = bax * sya;
   assign prod_b   = bay * sxa;
   assign edge_org = prod_a - prod_b;
   assign row_addr = PA_W'((BW'(FRAME_HEIGHT - 1) - y0_ff) * FRAME_WIDTH) + PA_W'(x0_ff);

   // ---------------------------------------------------------------- sample test
   logic signed [EW-1:0] fx8 [3], fy8 [3], fx16 [3], fy16 [3], ev [3], ev_abs [3];
   logic [2:0]    pos, neg;
   logic          covered;
   logic [MW-1:0] mag_c [3];
   logic [trzb_pkg::SUM_W-1:0] sum_c;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fx8[k]  = {{(EW-SW-3){fx_ff[k][SW-1]}}, fx_ff[k], 3'b000};
         fy8[k]  = {{(EW-SW-3){fy_ff[k][SW-1]}}, fy_ff[k], 3'b000};
         fx16[k] = {{(EW-SW-4){fx_ff[k][SW-1]}}, fx_ff[k], 4'b0000};
         fy16[k] = {{(EW-SW-4){fy_ff[k][SW-1]}}, fy_ff[k], 4'b0000};
         ev[k]   = edge_pix_ff[k] + (s_ff[1] ? fx8[k] : '0) + (s_ff[0] ? fy8[k] : '0);
         neg[k]  = ev[k][EW-1];
         pos[k]  = !ev[k][EW-1] && (ev[k] != '0);
         ev_abs[k] = neg[k] ? -ev[k] : ev[k];
      end
      // weight of a vertex is the edge facing it
      mag_c[0] = ev_abs[1][MW-1:0];
      mag_c[1] = ev_abs[2][MW-1:0];
      mag_c[2] = ev_abs[0][MW-1:0];
   end

   assign covered = (&pos) || (&neg);
   assign sum_c   = trzb_pkg::SUM_W'(mag_c[0]) + trzb_pkg::SUM_W'(mag_c[1])
                  + trzb_pkg::SUM_W'(mag_c[2]);

   // ---------------------------------------------------------------- depth
   logic [MW-1:0]    mag_sel;
   logic [DW-1:0]    z_sel;
   logic [MW+DW-1:0] mac_prod;
   logic             div_ge;
   logic [trzb_pkg::SDEPTH_W-1:0] new_depth, rd_depth;
   logic [KW-1:0]    rd_color;
   logic             win;

   always_comb begin
      case (mac_cnt_ff)
         2'd0:    begin mag_sel = mag_ff[0]; z_sel = vz_ff[0]; end
         2'd1:    begin mag_sel = mag_ff[1]; z_sel = vz_ff[1]; end
         default: begin mag_sel = mag_ff[2]; z_sel = vz_ff[2]; end
      endcase
   end

   assign mac_prod  = mag_sel * z_sel;
   assign div_ge    = acc_ff >= dvs_ff;
   assign new_depth = {1'b0, ~quo_ff};
   assign rd_depth  = samp_rdata_ff[trzb_pkg::SAMPLE_W-1:KW];
   assign rd_color  = samp_rdata_ff[KW-1:0];
   assign win       = covered_ff && (rd_depth > new_depth);

   // ---------------------------------------------------------------- resolve
   logic [9:0]    r_sum, g_sum, b_sum;
   logic [KW-1:0] mean_color;

   always_comb begin
      r_sum = '0; g_sum = '0; b_sum = '0;
      for (int i = 0; i < 4; i++) begin
         r_sum = r_sum + 10'(col_ff[i][23:16]);
         g_sum = g_sum + 10'(col_ff[i][15:8]);
         b_sum = b_sum + 10'(col_ff[i][7:0]);
      end
   end

   assign mean_color = {r_sum[9:2], g_sum[9:2], b_sum[9:2]};

   // ---------------------------------------------------------------- memory ports
   logic                          samp_we, res_we;
   logic [SA_W-1:0]               samp_waddr;
   logic [trzb_pkg::SAMPLE_W-1:0] samp_wdata;
   logic [PA_W-1:0]               res_waddr, res_raddr;
   logic [KW-1:0]                 res_wdata;
   logic [SA_W-1:0]               samp_addr;
   logic [31:0]                   idx_wide;
   logic                          clr_in_res, clr_last, in_range;

   assign samp_addr  = {pix_ff, s_ff};
   assign clr_last   = clr_cnt_ff == SA_W'(SAMPLE_COUNT - 1);
   assign clr_in_res = 32'(clr_cnt_ff) < 32'(PIXEL_COUNT);
   assign idx_wide   = 32'(index_ff);
   assign res_raddr  = idx_wide[PA_W-1:0];
   assign in_range   = idx_wide < 32'(PIXEL_COUNT);

   always_comb begin
      samp_we    = 1'b0;
      samp_waddr = samp_addr;
      samp_wdata = {new_depth, color_ff};
      res_we     = 1'b0;
      res_waddr  = pix_ff;
      res_wdata  = mean_color;
      if (cmd.clr_write) begin
         samp_we    = 1'b1;
         samp_waddr = clr_cnt_ff;
         samp_wdata = {trzb_pkg::DEPTH_FAR, {KW{1'b0}}};
         res_we     = clr_in_res;
         res_waddr  = clr_cnt_ff[PA_W-1:0];
         res_wdata  = '0;
      end else if (cmd.update) begin
         samp_we = win;
      end else if (cmd.resolve) begin
         res_we = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (samp_we) samp_mem[samp_waddr] <= samp_wdata;
      if (cmd.test) samp_rdata_ff <= samp_mem[samp_addr];
   end

   always_ff @(posedge clock) begin
      if (res_we) res_mem[res_waddr] <= res_wdata;
      if (cmd.res_read) res_rdata_ff <= res_mem[res_raddr];
   end

   // ---------------------------------------------------------------- counters
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      setup_cnt_in = setup_cnt_ff;
      mac_cnt_in   = mac_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      s_in         = s_ff;
      hit_in       = hit_ff;
      if (cmd.clr_write) clr_cnt_in = clr_last ? '0 : clr_cnt_ff + 1'b1;
      if (cmd.setup)     setup_cnt_in = (setup_cnt_ff == 2'd2) ? 2'd0 : setup_cnt_ff + 2'd1;
      if (cmd.mac)       mac_cnt_in = (mac_cnt_ff == 2'd2) ? 2'd0 : mac_cnt_ff + 2'd1;
      if (cmd.div)       div_cnt_in = div_cnt_ff + 4'd1;
      if (cmd.update) begin
         s_in   = s_ff + 2'd1;
         hit_in = hit_ff || win;
      end
      if (cmd.box) begin
         s_in         = 2'd0;
         hit_in       = 1'b0;
         setup_cnt_in = 2'd0;
      end
      if (cmd.step) hit_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         setup_cnt_ff <= '0;
         mac_cnt_ff   <= '0;
         div_cnt_ff   <= '0;
         s_ff         <= '0;
         hit_ff       <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         setup_cnt_ff <= setup_cnt_in;
         mac_cnt_ff   <= mac_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         s_ff         <= s_in;
         hit_ff       <= hit_in;
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         vx_ff[0] <= req_tdata[11:0];
         vy_ff[0] <= req_tdata[23:12];
         vz_ff[0] <= req_tdata[39:24];
         vx_ff[1] <= req_tdata[51:40];
         vy_ff[1] <= req_tdata[63:52];
         vz_ff[1] <= req_tdata[79:64];
         vx_ff[2] <= req_tdata[91:80];
         vy_ff[2] <= req_tdata[103:92];
         vz_ff[2] <= req_tdata[119:104];
         color_ff <= req_tdata[143:120];
         index_ff <= req_tdata[159:144];
         act_ff   <= req_tuser;
      end
      if (cmd.box) begin
         x0_ff <= BW'(lx[CW-1:4]);
         y0_ff <= BW'(ly[CW-1:4]);
         x1_ff <= x1_clip;
         y1_ff <= y1_clip;
      end
      if (cmd.setup) begin
         edge_base_ff[setup_cnt_ff] <= edge_org;
         edge_pix_ff[setup_cnt_ff]  <= edge_org;
         fx_ff[setup_cnt_ff]        <= -bay;
         fy_ff[setup_cnt_ff]        <= bax;
         px_ff      <= x0_ff;
         py_ff      <= y0_ff;
         pix_ff     <= row_addr;
         col_pix_ff <= row_addr;
      end
      if (cmd.test) begin
         for (int j = 0; j < 3; j++) mag_ff[j] <= mag_c[j];
         covered_ff <= covered;
         acc_ff     <= '0;
         dvs_ff     <= AW'(sum_c) << (QW - 1);
      end
      if (cmd.mac) acc_ff <= acc_ff + AW'(mac_prod);
      if (cmd.div) begin
         if (div_ge) acc_ff <= acc_ff - dvs_ff;
         quo_ff <= {quo_ff[QW-2:0], div_ge};
         dvs_ff <= dvs_ff >> 1;
      end
      if (cmd.update) col_ff[s_ff] <= win ? color_ff : rd_color;
      if (cmd.step) begin
         if (py_ff != y1_ff) begin
            py_ff  <= py_ff + 1'b1;
            pix_ff <= pix_ff - PA_W'(FRAME_WIDTH);
            for (int k = 0; k < 3; k++) edge_pix_ff[k] <= edge_pix_ff[k] + fy16[k];
         end else begin
            px_ff      <= px_ff + 1'b1;
            py_ff      <= y0_ff;
            col_pix_ff <= col_pix_ff + 1'b1;
            pix_ff     <= col_pix_ff + 1'b1;
            for (int k = 0; k < 3; k++) begin
               edge_base_ff[k] <= edge_base_ff[k] + fx16[k];
               edge_pix_ff[k]  <= edge_base_ff[k] + fx16[k];
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_color_ff  <= ((act_ff == trzb_pkg::ACT_READ) && in_range) ? res_rdata_ff : '0;
         rsp_action_ff <= act_ff;
      end
   end

   assign rsp_color  = rsp_color_ff;
   assign rsp_action = rsp_action_ff;

   assign status.clr_last    = clr_last;
   assign status.box_empty   = (x0_ff > x1_ff) || (y0_ff > y1_ff);
   assign status.setup_last  = setup_cnt_ff == 2'd2;
   assign status.covered     = covered;
   assign status.mac_last    = mac_cnt_ff == 2'd2;
   assign status.div_last    = div_cnt_ff == 4'd15;
   assign status.sample_last = s_ff == 2'd3;
   assign status.walk_last   = (px_ff == x1_ff) && (py_ff == y1_ff);

endmodule

// File: rtl/triangle_raster_msaa_zbuffer_core.sv
// ----------------------------------------------------------------------------
// triangle_raster_msaa_zbuffer_core: 4x supersampled triangle rasteriser
// flat-shaded triangles into a per-sample depth buffer with resolve
// ----------------------------------------------------------------------------
// One request at a time. A clear sweeps both stores one sample a cycle; the
// same sweep runs once after reset, during which req_tready stays low. A draw
// sets up the clipped bounding box and its edges, then for every pixel of the
// box tests each sample, takes three multiply-accumulate steps and a 16-step
// restoring divide for the depth of a covered sample, and ends with resolve and
// step. Every request with action clear, draw or read gives one response;
// action 3 is taken and gives none. A finished response waits in an output
// register.
module triangle_raster_msaa_zbuffer_core #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
   // vertex2_x, vertex2_y, vertex2_z, fill_color, pixel_index
   input  logic [159:0] req_tdata,
   // action
   input  logic [1:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pixel_color
   output logic [23:0]  rsp_tdata,
   // done_action
   output logic [1:0]   rsp_tuser
);

   trzb_pkg::cmd_type    cmd;
   trzb_pkg::status_type status;

   // controller: sequencing and handshake
   trzb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (trzb_pkg::action_type'(req_tuser)),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: edge walk, depth, stores and response payload
   trzb_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_color  (rsp_tdata),
      .rsp_action (rsp_tuser)
   );

`ifndef SYNTHESIS
   // req_tready is low in the cycle after a draw request is taken
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == trzb_pkg::ACT_DRAW)) |=> !req_tready)
      else $error("request taken straight after a draw");

   // only reads carry a colour
   a_zero_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != trzb_pkg::ACT_READ)) |-> (rsp_tdata == '0))
      else $error("non-read response with colour");

   // the unused action never gets a response
   a_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == trzb_pkg::ACT_CLEAR) || (rsp_tuser == trzb_pkg::ACT_DRAW)
                      || (rsp_tuser == trzb_pkg::ACT_READ)))
      else $error("response for unused action");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4x supersampled triangle rasteriser
// drives clear, draw and read requests over the stream ports, predicts the
// sample depth / colour stores and the resolved frame in a scoreboard and
// checks every response in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   localparam int FW = 256;
   localparam int FH = 256;
   localparam int PIX_N = FW * FH;
   localparam int SMP_N = PIX_N * 4;
   localparam logic [1:0] ACT_NONE = 2'd3;    // unused code, taken with no response
   localparam int WATCHDOG_LIMIT = 1500000;   // outlasts a whole clear sweep
   localparam int N_RANDOM = 480;

   // --------------------------------------------------------------------------
   // scoreboard: own copy of the sample and resolved stores
   // --------------------------------------------------------------------------
   class raster_scoreboard;
      bit [16:0] smp_depth [SMP_N];
      bit [23:0] smp_color [SMP_N];
      bit [23:0] pix_color [PIX_N];
      bit [23:0] exp_color [$];
      bit [1:0]  exp_action [$];
      int        errors;

      function new();
         wipe();
      endfunction

      function void wipe();
         for (int i = 0; i < SMP_N; i++) begin
            smp_depth[i] = '1;
            smp_color[i] = '0;
         end
         for (int i = 0; i < PIX_N; i++) pix_color[i] = '0;
      endfunction

      function longint edge_fn(longint ax, longint ay, longint bx, longint by,
                               longint qx, longint qy);
         return (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
      endfunction

      function longint absl(longint v);
         return v < 0 ? -v : v;
      endfunction

      function void raster(logic [159:0] d);
         longint vx [3];
         longint vy [3];
         longint vz [3];
         longint lx, hx, ly, hy, bx0, bx1, by0, by1, sx, sy, e01, e12, e20;
         longint w0, w1, w2, z;
         bit [23:0] fill;
         bit [16:0] dep;
         int pix, si, r, g, b;
         bit hit;
         for (int k = 0; k < 3; k++) begin
            vx[k] = longint'(d[40*k +: 12]);
            vy[k] = longint'(d[40*k+12 +: 12]);
            vz[k] = longint'(d[40*k+24 +: 16]);
         end
         fill = d[143:120];
         lx = vx[0]; hx = vx[0]; ly = vy[0]; hy = vy[0];
         for (int k = 1; k < 3; k++) begin
            if (vx[k] < lx) lx = vx[k];
            if (vx[k] > hx) hx = vx[k];
            if (vy[k] < ly) ly = vy[k];
            if (vy[k] > hy) hy = vy[k];
         end
         bx0 = lx / 16; bx1 = (hx + 15) / 16;
         by0 = ly / 16; by1 = (hy + 15) / 16;
         if (bx1 > FW - 1) bx1 = FW - 1;
         if (by1 > FH - 1) by1 = FH - 1;
         for (longint px = bx0; px <= bx1; px++) begin
            for (longint py = by0; py <= by1; py++) begin
               pix = int'((FH - 1 - py) * FW + px);
               hit = 0;
               for (int s = 0; s < 4; s++) begin
                  // sample order: (1/4,1/4) (1/4,3/4) (3/4,1/4) (3/4,3/4)
                  sx = px * 16 + ((s >= 2) ? 12 : 4);
                  sy = py * 16 + ((s % 2) ? 12 : 4);
                  e01 = edge_fn(vx[0], vy[0], vx[1], vy[1], sx, sy);
                  e12 = edge_fn(vx[1], vy[1], vx[2], vy[2], sx, sy);
                  e20 = edge_fn(vx[2], vy[2], vx[0], vy[0], sx, sy);
                  if ((e01 > 0 && e12 > 0 && e20 > 0) ||
                      (e01 < 0 && e12 < 0 && e20 < 0)) begin
                     w0 = absl(e12); w1 = absl(e20); w2 = absl(e01);
                     z = (w0 * vz[0] + w1 * vz[1] + w2 * vz[2]) / (w0 + w1 + w2);
                     dep = 17'(65535 - z);
                     si = pix * 4 + s;
                     if (smp_depth[si] > dep) begin
                        smp_depth[si] = dep;
                        smp_color[si] = fill;
                        hit = 1;
                     end
                  end
               end
               if (hit) begin
                  r = 0; g = 0; b = 0;
                  for (int s = 0; s < 4; s++) begin
                     r += int'(smp_color[pix*4+s][23:16]);
                     g += int'(smp_color[pix*4+s][15:8]);
                     b += int'(smp_color[pix*4+s][7:0]);
                  end
                  pix_color[pix] = {8'(r / 4), 8'(g / 4), 8'(b / 4)};
               end
            end
         end
      endfunction

      // accepted request: update the stores and queue the response it causes
      function void note_request(logic [1:0] act, logic [159:0] d);
         bit [23:0] col;
         col = '0;
         case (act)
            trzb_pkg::ACT_CLEAR: wipe();
            trzb_pkg::ACT_DRAW:  raster(d);
            trzb_pkg::ACT_READ: begin
               if (int'(d[159:144]) < PIX_N) col = pix_color[d[159:144]];
            end
            default: return;
         endcase
         exp_color.push_back(col);
         exp_action.push_back(act);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      endtask

      task check_response(logic [23:0] col, logic [1:0] act);
         if (exp_color.size() == 0) begin
            report("unexpected response, action", 32'(act), 32'd0);
            return;
         end
         if (col !== exp_color[0]) report("pixel_color", 32'(col), 32'(exp_color[0]));
         if (act !== exp_action[0]) report("done_action", 32'(act), 32'(exp_action[0]));
         void'(exp_color.pop_front());
         void'(exp_action.pop_front());
      endtask

      function int pending();
         return exp_color.size();
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // block and its ports
   // --------------------------------------------------------------------------
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;    // v0x v0y v0z v1x v1y v1z v2x v2y v2z colour index
   logic [1:0]   req_tuser = '0;    // action
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [23:0]  rsp_tdata;         // pixel_color
   logic [1:0]   rsp_tuser;         // done_action

   raster_scoreboard sb = new();
   int  sent_count = 0;
   int  rsp_count = 0;
   bit  quiet_tail = 0;             // no idling on either side near the end
   int  idle_cycles = 0;

   triangle_raster_msaa_zbuffer_core #(.FRAME_WIDTH(FW), .FRAME_HEIGHT(FH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog: counts cycles with no request or response taken
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // request side
   // --------------------------------------------------------------------------
   function automatic logic [159:0] pack_fields(int x0, int y0, int z0, int x1, int y1,
                                                int z1, int x2, int y2, int z2,
                                                int col, int idx);
      return {16'(idx), 24'(col), 16'(z2), 12'(y2), 12'(x2), 16'(z1), 12'(y1),
              12'(x1), 16'(z0), 12'(y0), 12'(x0)};
   endfunction

   // present one request from a falling edge until it is taken
   task automatic send_request(logic [1:0] act, logic [159:0] d);
      int gap;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid = 0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = act;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, d);
      sent_count++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // small triangle near a corner pixel, spread in 1/16 pixel units
   task automatic draw_small(int cx, int cy, int spread);
      send_request(trzb_pkg::ACT_DRAW, pack_fields(
         cx + $urandom_range(0, spread), cy + $urandom_range(0, spread), $urandom,
         cx + $urandom_range(0, spread), cy + $urandom_range(0, spread), $urandom,
         cx + $urandom_range(0, spread), cy + $urandom_range(0, spread), $urandom,
         $urandom, $urandom));
   endtask

   task automatic read_near(int cx, int cy);
      int px, py;
      px = cx / 16 + $urandom_range(0, 4);
      py = cy / 16 + $urandom_range(0, 4);
      if (px > FW - 1) px = FW - 1;
      if (py > FH - 1) py = FH - 1;
      send_request(trzb_pkg::ACT_READ, pack_fields($urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         (FH - 1 - py) * FW + px));
   endtask

   // --------------------------------------------------------------------------
   // response side, with one long hold-off to back the block up
   // --------------------------------------------------------------------------
   initial begin : rsp_side
      int gap;
      bit held;
      held = 0;
      forever begin
         @(negedge clock);
         if (!held && rsp_count >= 30) begin
            held = 1;
            rsp_tready = 0;
            repeat (4000) @(negedge clock);
         end
         if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_tready = 0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata, rsp_tuser);
            rsp_count++;
         end
      end
   end

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      int cx, cy, pick;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed part
      // plain triangle, then the same again: equal depth keeps old samples
      send_request(trzb_pkg::ACT_DRAW, pack_fields(160, 160, 1000, 240, 170, 2000, 180,
                                         250, 3000, 24'hff8040, 0));
      send_request(trzb_pkg::ACT_DRAW, pack_fields(160, 160, 1000, 240, 170, 2000, 180,
                                         250, 3000, 24'h0000ff, 0));
      read_near(160, 160);
      // nearer triangle over it, opposite winding, depth extremes
      send_request(trzb_pkg::ACT_DRAW, pack_fields(150, 150, 65535, 170, 260, 65535, 260,
                                         150, 0, 24'hffffff, 0));
      send_request(trzb_pkg::ACT_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                         (FH - 1 - 10) * FW + 10));
      // degenerate: collinear vertices
      send_request(trzb_pkg::ACT_DRAW, pack_fields(300, 300, 0, 340, 340, 0, 380, 380, 0,
                                         24'h123456, 0));
      // box crossing the top right frame edge, clipped
      send_request(trzb_pkg::ACT_DRAW, pack_fields(4060, 4060, 5, 4095, 4080, 9, 4070,
                                         4095, 7, 24'hffffff, 0));
      send_request(trzb_pkg::ACT_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255));
      send_request(trzb_pkg::ACT_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535));
      send_request(trzb_pkg::ACT_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // corner at the origin, all-zero coordinate bits
      send_request(trzb_pkg::ACT_DRAW, pack_fields(0, 0, 0, 40, 0, 100, 0, 40, 200,
                                         24'hffffff, 0));
      send_request(trzb_pkg::ACT_READ, pack_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                         (FH - 1) * FW));
      // action 3 is taken without a response
      send_request(ACT_NONE, '1);
      send_request(ACT_NONE, '0);
      // one larger triangle
      send_request(trzb_pkg::ACT_DRAW, pack_fields(800, 800, 30000, 1300, 850, 20000, 900,
                                         1280, 10000, 24'h55aa33, 0));
      read_near(1000, 1000);
      // clear, then read back zero
      send_request(trzb_pkg::ACT_CLEAR, '1);
      read_near(160, 160);

      // random part: small triangles packed into one region so depth tests bite
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 60) quiet_tail = 1;
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) begin
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
         end else begin
            cx = $urandom_range(600, 760);
            cy = $urandom_range(600, 760);
         end
         if (n == N_RANDOM / 2)
            send_request(trzb_pkg::ACT_CLEAR,
                         {$urandom, $urandom, $urandom, $urandom, $urandom});
         else if (pick < 60)
            draw_small(cx, cy, $urandom_range(0, 9) == 0 ? 64 : 40);
         else if (pick < 90)
            read_near(cx, cy);
         else if (pick < 95)
            send_request(trzb_pkg::ACT_READ,
                         {$urandom, $urandom, $urandom, $urandom, $urandom});
         else
            send_request(ACT_NONE, {$urandom, $urandom, $urandom, $urandom, $urandom});
      end
      drop_valid();

      // drain, then allow for any request still inside the block
      while (sb.pending() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
